// ===== sv/mlpe_pkg.sv =====
// shared types, constants and the morse pattern table
`timescale 1ns / 1ps
package mlpe_pkg;

	localparam int unsigned TimeW   = 16;
	localparam int unsigned SymMax  = 5;
	localparam int unsigned LenW    = 3;
	localparam int unsigned CodeW   = 8;
	localparam int unsigned CfgIdxW = 2;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] REG_DOT  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_DASH = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_GAP  = 2'd2;

	localparam logic [TimeW-1:0] DOT_RST  = 16'd200;
	localparam logic [TimeW-1:0] DASH_RST = 16'd600;
	localparam logic [TimeW-1:0] GAP_RST  = 16'd200;

	localparam logic [CodeW-1:0] CHAR_A    = 8'h41;
	localparam logic [CodeW-1:0] CHAR_Z    = 8'h5A;
	localparam logic [CodeW-1:0] CHAR_0    = 8'h30;
	localparam logic [CodeW-1:0] CHAR_9    = 8'h39;
	localparam logic [5:0]       NUM_ALPHA = 6'd26;

	// symbol count and symbols, first symbol in the highest used bit, 1 = dash
	typedef struct packed {
		logic [LenW-1:0]   len;
		logic [SymMax-1:0] bits;
	} pat_t;

	typedef struct packed {
		logic [TimeW-1:0] dot;
		logic [TimeW-1:0] dash;
		logic [TimeW-1:0] gap;
	} timing_t;

	typedef struct packed {
		logic             led;
		logic [TimeW-1:0] hold;
		logic             last;
	} res_t;

	function automatic pat_t pat_of(input logic [5:0] idx);
		pat_t p;
		unique case (idx)
			6'd0:  p = '{3'd2, 5'h01};
			6'd1:  p = '{3'd4, 5'h08};
			6'd2:  p = '{3'd4, 5'h0A};
			6'd3:  p = '{3'd3, 5'h04};
			6'd4:  p = '{3'd1, 5'h00};
			6'd5:  p = '{3'd4, 5'h02};
			6'd6:  p = '{3'd3, 5'h06};
			6'd7:  p = '{3'd4, 5'h00};
			6'd8:  p = '{3'd2, 5'h00};
			6'd9:  p = '{3'd4, 5'h07};
			6'd10: p = '{3'd3, 5'h05};
			6'd11: p = '{3'd4, 5'h04};
			6'd12: p = '{3'd2, 5'h03};
			6'd13: p = '{3'd2, 5'h02};
			6'd14: p = '{3'd3, 5'h07};
			6'd15: p = '{3'd4, 5'h06};
			6'd16: p = '{3'd4, 5'h0D};
			6'd17: p = '{3'd3, 5'h02};
			6'd18: p = '{3'd3, 5'h00};
			6'd19: p = '{3'd1, 5'h01};
			6'd20: p = '{3'd3, 5'h01};
			6'd21: p = '{3'd4, 5'h01};
			6'd22: p = '{3'd3, 5'h03};
			6'd23: p = '{3'd4, 5'h09};
			6'd24: p = '{3'd4, 5'h0B};
			6'd25: p = '{3'd4, 5'h0C};
			6'd26: p = '{3'd5, 5'h1F};
			6'd27: p = '{3'd5, 5'h0F};
			6'd28: p = '{3'd5, 5'h07};
			6'd29: p = '{3'd5, 5'h03};
			6'd30: p = '{3'd5, 5'h01};
			6'd31: p = '{3'd5, 5'h00};
			6'd32: p = '{3'd5, 5'h10};
			6'd33: p = '{3'd5, 5'h18};
			6'd34: p = '{3'd5, 5'h1C};
			6'd35: p = '{3'd5, 5'h1E};
			default: p = '0;
		endcase
		return p;
	endfunction

	// len of zero means the code has no pattern
	function automatic pat_t morse_lookup(input logic [CodeW-1:0] code);
		logic [CodeW-1:0] d;
		pat_t p;
		d = '0;
		p = '0;
		if (code >= CHAR_A && code <= CHAR_Z) begin
			d = code - CHAR_A;
			p = pat_of(d[5:0]);
		end else if (code >= CHAR_0 && code <= CHAR_9) begin
			d = code - CHAR_0;
			p = pat_of(d[5:0] + NUM_ALPHA);
		end
		return p;
	endfunction

endpackage

// ===== sv/mlpe_front.sv =====
// front end: takes characters, looks up the pattern, queues it for the back end
`timescale 1ns / 1ps
module mlpe_front import mlpe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [CodeW-1:0] char_code,
	output logic             full,
	output logic             pat_avail,
	output pat_t             pat_head,
	input  logic             take
);

	pat_t       lookup;
	logic       wr_en;
	pat_t       q_mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign lookup    = morse_lookup(char_code);
	assign full      = (cnt_q == 2'd2);
	// codes without a pattern are accepted and dropped
	assign wr_en     = push && !full && (lookup.len != '0);
	assign pat_avail = (cnt_q != 2'd0);
	assign pat_head  = q_mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem_q[wptr_q] <= lookup;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wptr_q <= !wptr_q;
			end
			if (take) begin
				rptr_q <= !rptr_q;
			end
			unique case ({wr_en, take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("pattern queue count out of range");
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> cnt_q != 2'd0) else $error("pattern taken from empty queue");
	a_no_blank: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> lookup.len != '0 && lookup.len <= LenW'(SymMax))
		else $error("empty or oversized pattern queued");

endmodule

// ===== sv/mlpe_back.sv =====
// back end: walks one pattern and queues its on/off intervals
`timescale 1ns / 1ps
module mlpe_back import mlpe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pat_avail,
	input  pat_t             pat_head,
	output logic             take,
	input  timing_t          times,
	output logic             empty,
	input  logic             pop,
	output logic             led_level,
	output logic [TimeW-1:0] hold_ms,
	output logic             last
);

	logic              busy_q;
	logic              phase_q;
	logic [SymMax-1:0] sym_q;
	logic [LenW-1:0]   left_q;
	res_t              res;
	logic              gen;
	logic              rd_en;
	res_t              o_mem_q [2];
	logic              o_wptr_q;
	logic              o_rptr_q;
	logic [1:0]        o_cnt_q;

	assign take  = !busy_q && pat_avail;
	assign gen   = busy_q && (o_cnt_q != 2'd2);
	assign rd_en = pop && !empty;

	// phase 0: led on for the symbol, phase 1: the gap after it
	always_comb begin
		res.led  = !phase_q;
		res.hold = phase_q ? times.gap : (sym_q[SymMax-1] ? times.dash : times.dot);
		res.last = phase_q && (left_q == LenW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
			end else if (gen) begin
				phase_q <= !phase_q;
				if (phase_q && left_q == LenW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sym_q  <= pat_head.bits << (LenW'(SymMax) - pat_head.len);
			left_q <= pat_head.len;
		end else if (gen && phase_q) begin
			sym_q  <= sym_q << 1;
			left_q <= left_q - LenW'(1);
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (gen) begin
			o_mem_q[o_wptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_wptr_q <= 1'b0;
			o_rptr_q <= 1'b0;
			o_cnt_q  <= 2'd0;
		end else begin
			if (gen) begin
				o_wptr_q <= !o_wptr_q;
			end
			if (rd_en) begin
				o_rptr_q <= !o_rptr_q;
			end
			unique case ({gen, rd_en})
				2'b10:   o_cnt_q <= o_cnt_q + 2'd1;
				2'b01:   o_cnt_q <= o_cnt_q - 2'd1;
				default: o_cnt_q <= o_cnt_q;
			endcase
		end
	end

	assign empty     = (o_cnt_q == 2'd0);
	assign led_level = o_mem_q[o_rptr_q].led;
	assign hold_ms   = o_mem_q[o_rptr_q].hold;
	assign last      = o_mem_q[o_rptr_q].last;

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		o_cnt_q != 2'd3) else $error("result queue count out of range");
	a_last_is_gap: assert property (@(posedge clk) disable iff (!arst_n)
		gen && res.last |-> !res.led) else $error("last flag on an led-on interval");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		gen && res.last |=> !busy_q) else $error("still busy after last interval");
	a_busy_left: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> left_q != '0) else $error("busy with no symbols left");

endmodule

// ===== sv/morse_led_pattern_encoder.sv =====
// top level: morse code encoder producing led on/off intervals
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   input    | push / full        | char_code[7:0]
//   result   | pop / empty        | led_level, hold_ms[15:0], last
//   config   | cfg_wr             | cfg_idx[1:0], cfg_data[15:0]
//
// a character with n symbols (1 to 5) gives 2n result items, one per cycle once
// loaded while the result queue has room; the back end takes a new pattern only when idle
// characters outside A-Z and 0-9 are accepted and dropped in the front end
// a two-entry pattern queue keeps input open while the back end works; full
// rises when both entries hold patterns; pop stalls halt generation only once
// the two-entry result queue fills; reset clears queues and loads default times
`timescale 1ns / 1ps
module morse_led_pattern_encoder import mlpe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// character input
	input  logic               push,
	output logic               full,
	input  logic [CodeW-1:0]   char_code,
	// interval output
	output logic               empty,
	input  logic               pop,
	output logic               led_level,
	output logic [TimeW-1:0]   hold_ms,
	output logic               last,
	// configuration writes
	input  logic               cfg_wr,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [TimeW-1:0]   cfg_data
);

	timing_t times_q;
	logic    pat_avail;
	pat_t    pat_head;
	logic    take;

	// interval time registers; writes to an unused index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			times_q.dot  <= DOT_RST;
			times_q.dash <= DASH_RST;
			times_q.gap  <= GAP_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DOT:  times_q.dot  <= cfg_data;
				REG_DASH: times_q.dash <= cfg_data;
				REG_GAP:  times_q.gap  <= cfg_data;
				default:  times_q      <= times_q;
			endcase
		end
	end

	// front end: lookup and pattern queue
	mlpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_code (char_code),
		.full      (full),
		.pat_avail (pat_avail),
		.pat_head  (pat_head),
		.take      (take)
	);

	// back end: symbol sequencer and result queue
	mlpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pat_avail (pat_avail),
		.pat_head  (pat_head),
		.take      (take),
		.times     (times_q),
		.empty     (empty),
		.pop       (pop),
		.led_level (led_level),
		.hold_ms   (hold_ms),
		.last      (last)
	);

endmodule

// ===== sim/morse_interval_checker.sv =====
// checker: predicts led intervals per character and compares popped items
`timescale 1ns / 1ps
module morse_interval_checker import mlpe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [CodeW-1:0]   char_code,
	input  logic               empty,
	input  logic               pop,
	input  logic               led_level,
	input  logic [TimeW-1:0]   hold_ms,
	input  logic               last,
	input  logic               cfg_wr,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [TimeW-1:0]   cfg_data,
	output int unsigned        mismatches,
	output int unsigned        pending
);

	timing_t     cur;
	res_t        intervals_due[$];
	int unsigned popped;

	function automatic string morse_of(input logic [CodeW-1:0] code);
		case (code)
			"A": return ".-";    "B": return "-...";  "C": return "-.-.";
			"D": return "-..";   "E": return ".";     "F": return "..-.";
			"G": return "--.";   "H": return "....";  "I": return "..";
			"J": return ".---";  "K": return "-.-";   "L": return ".-..";
			"M": return "--";    "N": return "-.";    "O": return "---";
			"P": return ".--.";  "Q": return "--.-";  "R": return ".-.";
			"S": return "...";   "T": return "-";     "U": return "..-";
			"V": return "...-";  "W": return ".--";   "X": return "-..-";
			"Y": return "-.--";  "Z": return "--..";
			"0": return "-----"; "1": return ".----"; "2": return "..---";
			"3": return "...--"; "4": return "....-"; "5": return ".....";
			"6": return "-...."; "7": return "--..."; "8": return "---..";
			"9": return "----.";
			default: return "";
		endcase
	endfunction

	task automatic predict_intervals(input logic [CodeW-1:0] code);
		string s;
		res_t  r;
		int    k;
		s = morse_of(code);
		for (k = 0; k < s.len(); k++) begin
			r.led  = 1'b1;
			r.hold = (s[k] == "-") ? cur.dash : cur.dot;
			r.last = 1'b0;
			intervals_due.push_back(r);
			r.led  = 1'b0;
			r.hold = cur.gap;
			r.last = (k == s.len() - 1);
			intervals_due.push_back(r);
		end
	endtask

	task automatic report(input string msg);
		$display("%0t morse check: %s", $time, msg);
		mismatches++;
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			cur.dot  = DOT_RST;
			cur.dash = DASH_RST;
			cur.gap  = GAP_RST;
			intervals_due.delete();
			popped = 0;
			pending <= 0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_DOT:  cur.dot  = cfg_data;
					REG_DASH: cur.dash = cfg_data;
					REG_GAP:  cur.gap  = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (intervals_due.size() == 0) begin
					report($sformatf("item %0d popped with nothing expected", popped));
				end else begin
					want = intervals_due.pop_front();
					if (led_level !== want.led)
						report($sformatf("item %0d led_level want %0b got %0b",
							popped, want.led, led_level));
					if (hold_ms !== want.hold)
						report($sformatf("item %0d hold_ms want %0d got %0d",
							popped, want.hold, hold_ms));
					if (last !== want.last)
						report($sformatf("item %0d last want %0b got %0b",
							popped, want.last, last));
				end
				popped++;
			end
			if (push && !full)
				predict_intervals(char_code);
			pending <= intervals_due.size();
		end
	end

endmodule

// ===== sim/tb_morse_led_pattern_encoder.sv =====
// testbench top: character stimulus, result-side stalls, watchdog and verdict
`timescale 1ns / 1ps
module tb_morse_led_pattern_encoder;
	import mlpe_pkg::*;

	// index past the register list, writes to it must be dropped
	localparam logic [CfgIdxW-1:0] REG_NONE = 2'd3;

	// extra wait at the end of a drain, after every expected interval is popped
	localparam int unsigned SETTLE      = 16;
	// receiver hold-off long enough to back up both internal queues
	localparam int unsigned HOLD_CYCLES = 150;
	// cycles with no accepted item before the run is declared hung
	localparam int unsigned LIMIT       = 3000;
	// valid characters per random phase
	localparam int unsigned PHASE_CHARS = 23;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               push      = 1'b0;
	logic               full;
	logic [CodeW-1:0]   char_code = '0;
	logic               empty;
	logic               pop       = 1'b0;
	logic               led_level;
	logic [TimeW-1:0]   hold_ms;
	logic               last;
	logic               cfg_wr    = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx   = '0;
	logic [TimeW-1:0]   cfg_data  = '0;

	int unsigned mismatches;
	int unsigned pending;

	// handshake between sender and receiver for the long hold-off
	bit squeeze = 1'b0;
	bit holding = 1'b0;
	// both sides run with no idling while set
	bit no_gaps = 1'b0;

	int unsigned quiet_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	morse_led_pattern_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_code (char_code),
		.empty     (empty),
		.pop       (pop),
		.led_level (led_level),
		.hold_ms   (hold_ms),
		.last      (last),
		.cfg_wr    (cfg_wr),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	morse_interval_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.char_code  (char_code),
		.empty      (empty),
		.pop        (pop),
		.led_level  (led_level),
		.hold_ms    (hold_ms),
		.last       (last),
		.cfg_wr     (cfg_wr),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// register value, extremes and zero now and then
	function automatic logic [TimeW-1:0] pick_time();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 16'd1;
			default: return TimeW'($urandom_range(1, 65535));
		endcase
	endfunction

	// mostly letters and digits, the rest any 8-bit code
	function automatic logic [CodeW-1:0] pick_char(output bit valid);
		int unsigned k;
		valid = 1'b1;
		if ($urandom_range(0, 3) == 0) begin
			k = $urandom_range(0, 255);
			valid = (k >= CHAR_A && k <= CHAR_Z) || (k >= CHAR_0 && k <= CHAR_9);
			return CodeW'(k);
		end
		k = $urandom_range(0, 35);
		if (k < NUM_ALPHA)
			return CHAR_A + CodeW'(k);
		return CHAR_0 + CodeW'(k - NUM_ALPHA);
	endfunction

	// present one item and hold it until the block takes it; push stays high
	task automatic send_char(input logic [CodeW-1:0] code);
		push      <= 1'b1;
		char_code <= code;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic pause_input(input int unsigned n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// register writes only happen with push low and nothing in flight
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] val);
		cfg_wr   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering items, wait for every expected interval, then let
	// any dropped character clear the front end
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_phase(input int unsigned n_valid);
		int unsigned      sent;
		bit               valid;
		logic [CodeW-1:0] code;
		sent = 0;
		while (sent < n_valid) begin
			code = pick_char(valid);
			send_char(code);
			if (valid)
				sent++;
			pause_input(gap_len());
		end
	endtask

	// receiver: pop runs with random stalls, a long hold-off on request
	initial begin : receiver
		int unsigned n;
		forever begin
			if (squeeze) begin
				holding = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
				squeeze = 1'b0;
			end else if (no_gaps) begin
				pop <= 1'b1;
				@(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				n = gap_len();
				if (n > 0) begin
					pop <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// watchdog on accepted items at either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= LIMIT) begin
			$display("tb_morse_led_pattern_encoder: errors");
			$finish;
		end
	end

	initial begin : stimulus
		logic [CodeW-1:0] reset_set[15];
		logic [CodeW-1:0] code;
		bit               valid;
		int               i;

		reset_set = '{"E", "T", "0", "5", "A", "Z", "9", "Q",
			8'h00, 8'hFF, 8'h40, 8'h5B, 8'h2F, 8'h3A, "a"};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default timing: shortest and longest patterns, codes just outside
		// both ranges, all-zero and all-one codes, a lowercase letter
		foreach (reset_set[j]) begin
			send_char(reset_set[j]);
			pause_input(gap_len());
		end
		drain();

		// zero dot time, widest dash, tiny gap; unused index ignored
		write_reg(REG_DOT, '0);
		write_reg(REG_DASH, '1);
		write_reg(REG_GAP, 16'd1);
		write_reg(REG_NONE, 16'h5A5A);
		send_char("B");
		pause_input(gap_len());
		send_char("Y");
		pause_input(gap_len());

		// long receiver hold-off while characters keep coming back to back
		squeeze = 1'b1;
		wait (holding);
		for (i = 0; i < 8; i++) begin
			do
				code = pick_char(valid);
			while (!valid);
			send_char(code);
		end
		drain();

		// the other extremes: widest dot, shortest dash, zero gap
		write_reg(REG_DOT, '1);
		write_reg(REG_DASH, 16'd1);
		write_reg(REG_GAP, '0);
		send_char("K");
		pause_input(gap_len());
		send_char("0");
		drain();

		// random timings, one phase with neither side idling
		for (i = 0; i < 5; i++) begin
			write_reg(REG_DOT, pick_time());
			write_reg(REG_DASH, pick_time());
			write_reg(REG_GAP, pick_time());
			if (i == 3)
				write_reg(REG_NONE, pick_time());
			no_gaps = (i == 2);
			random_phase(PHASE_CHARS);
			drain();
			no_gaps = 1'b0;
		end

		if (mismatches == 0 && pending == 0)
			$display("tb_morse_led_pattern_encoder: clean");
		else
			$display("tb_morse_led_pattern_encoder: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mlpe_pkg.sv
sv/mlpe_front.sv
sv/mlpe_back.sv
sv/morse_led_pattern_encoder.sv
sim/morse_interval_checker.sv
sim/tb_morse_led_pattern_encoder.sv
